/* rtl/core/line_rasterizer_defines.svh */
// assertion helpers shared by the rasterizer rtl
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

`ifndef SYNTH
`define LRAST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LRAST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRAST_ASSERT(label, clk, rst_n, prop, msg)
`define LRAST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/core/lrast_pkg.sv */
package lrast_pkg;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    typedef logic signed [1:0] t_step;

    localparam t_step STEP_NEG  = 2'sb11;
    localparam t_step STEP_ZERO = 2'sb00;
    localparam t_step STEP_POS  = 2'sb01;

    // per-line direction set handed from the front end to the stepper
    typedef struct packed {
        t_step diag_x;
        t_step diag_y;
        t_step axis_x;
        t_step axis_y;
    } t_dirs;

    localparam int DIRS_W = $bits(t_dirs);

    localparam int          PADDR_W         = 3;
    localparam int          PDATA_W         = 32;
    localparam int          COLOR_W         = 24;
    localparam logic [0:0]  REG_PIXEL_COLOR = 1'b0;
    localparam logic [23:0] COLOR_RESET     = 24'hFF0000;

endpackage

/* rtl/core/lrast_cmd_if.sv */
interface lrast_cmd_if #(
    parameter int CW = 12
);
    logic                 valid;
    logic                 ready;
    logic [0:0]           opcode;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;

    modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

/* rtl/core/lrast_pix_if.sv */
interface lrast_pix_if #(
    parameter int CW = 12
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] pixel_x;
    logic signed [CW-1:0] pixel_y;
    logic [23:0]          pixel_rgb;
    logic                 last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_rgb, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_rgb, last_pixel, output ready);
endinterface

/* rtl/core/lrast_fifo.sv */
`include "line_rasterizer_defines.svh"

module lrast_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0]   LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `LRAST_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT, "queue count overrun")
    `LRAST_ASSERT_NEXT(a_ptr_gap, i_clk, i_rst_n, r_count == '0, r_count == '0 || r_rd_ptr != r_wr_ptr || r_count == FULL_CNT, "queue pointers out of step")

endmodule

/* rtl/core/lrast_front.sv */
module lrast_front #(
    parameter int CW = 12
) (
    lrast_cmd_if.sink                 i_cmd,
    input  logic                      i_full,
    output logic                      o_push,
    output logic                      o_is_load,
    output logic [CW-1:0]             o_start_x,
    output logic [CW-1:0]             o_start_y,
    output logic [CW-1:0]             o_major,
    output logic [CW-1:0]             o_minor,
    output lrast_pkg::t_dirs          o_dirs
);
    import lrast_pkg::*;

    logic signed [CW:0] w, h;
    logic [CW:0]        w_neg, h_neg;
    logic [CW-1:0]      aw, ah;
    t_step              sx, sy;

    assign i_cmd.ready = !i_full;
    assign o_push      = i_cmd.valid && !i_full;
    assign o_is_load   = (i_cmd.opcode == OP_LOAD);
    assign o_start_x   = i_cmd.start_x;
    assign o_start_y   = i_cmd.start_y;

    always_comb begin
        w     = {i_cmd.end_x[CW-1], i_cmd.end_x} - {i_cmd.start_x[CW-1], i_cmd.start_x};
        h     = {i_cmd.end_y[CW-1], i_cmd.end_y} - {i_cmd.start_y[CW-1], i_cmd.start_y};
        w_neg = -w;
        h_neg = -h;
        aw    = w[CW] ? w_neg[CW-1:0] : w[CW-1:0];
        ah    = h[CW] ? h_neg[CW-1:0] : h[CW-1:0];
        sx    = w[CW] ? STEP_NEG : ((w == '0) ? STEP_ZERO : STEP_POS);
        sy    = h[CW] ? STEP_NEG : ((h == '0) ? STEP_ZERO : STEP_POS);

        o_dirs.diag_x = sx;
        o_dirs.diag_y = sy;
        // tie goes to y as the major axis
        if (aw > ah) begin
            o_major       = aw;
            o_minor       = ah;
            o_dirs.axis_x = sx;
            o_dirs.axis_y = STEP_ZERO;
        end else begin
            o_major       = ah;
            o_minor       = aw;
            o_dirs.axis_x = STEP_ZERO;
            o_dirs.axis_y = sy;
        end
    end

endmodule

/* rtl/core/lrast_back.sv */
`include "line_rasterizer_defines.svh"

module lrast_back #(
    parameter int CW = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    output logic                         o_pop,
    input  logic                         i_is_load,
    input  logic [CW-1:0]                i_start_x,
    input  logic [CW-1:0]                i_start_y,
    input  logic [CW-1:0]                i_major,
    input  logic [CW-1:0]                i_minor,
    input  lrast_pkg::t_dirs             i_dirs,
    input  logic [lrast_pkg::COLOR_W-1:0] i_color,
    lrast_pix_if.source                  o_pix
);
    import lrast_pkg::*;

    logic [CW-1:0]  r_cur_x, r_cur_y;
    logic [CW:0]    r_err, r_left;
    logic [CW-1:0]  r_major, r_minor;
    t_dirs          r_dirs;
    logic           r_busy;

    logic           r_out_valid;
    logic [CW-1:0]  r_out_x, r_out_y;
    logic [COLOR_W-1:0] r_out_rgb;
    logic           r_out_last;

    logic [CW:0]    sum, n_err, n_left;
    logic           go_diag, do_step;
    t_step          mx, my;
    logic [CW-1:0]  n_x, n_y;

    assign o_pop   = !i_empty && (!r_out_valid || o_pix.ready);
    assign do_step = o_pop && !i_is_load && r_busy;

    always_comb begin
        sum     = r_err + {1'b0, r_minor};
        go_diag = (sum >= {1'b0, r_major});
        n_err   = go_diag ? sum - {1'b0, r_major} : sum;
        mx      = go_diag ? r_dirs.diag_x : r_dirs.axis_x;
        my      = go_diag ? r_dirs.diag_y : r_dirs.axis_y;
        n_x     = r_cur_x + {{(CW-2){mx[1]}}, mx};
        n_y     = r_cur_y + {{(CW-2){my[1]}}, my};
        n_left  = r_left - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_is_load) begin
                r_busy <= 1'b1;
            end else if (do_step) begin
                r_busy <= (n_left != '0);
            end
            if (do_step) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_is_load) begin
            r_cur_x <= i_start_x;
            r_cur_y <= i_start_y;
            r_major <= i_major;
            r_minor <= i_minor;
            r_dirs  <= i_dirs;
            r_err   <= {2'b00, i_major[CW-1:1]};
            r_left  <= {1'b0, i_major} + 1'b1;
        end else if (do_step) begin
            r_cur_x <= n_x;
            r_cur_y <= n_y;
            r_err   <= n_err;
            r_left  <= n_left;
        end
        if (do_step) begin
            r_out_x    <= r_cur_x;
            r_out_y    <= r_cur_y;
            r_out_rgb  <= i_color;
            r_out_last <= (r_left == {{CW{1'b0}}, 1'b1});
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_x    = r_out_x;
    assign o_pix.pixel_y    = r_out_y;
    assign o_pix.pixel_rgb  = r_out_rgb;
    assign o_pix.last_pixel = r_out_last;

    `LRAST_ASSERT(a_busy_left, i_clk, i_rst_n, r_busy |-> (r_left != '0), "busy with no pixels left")
    `LRAST_ASSERT(a_err_bound, i_clk, i_rst_n, r_busy |-> (r_err <= {1'b0, r_major}), "error above major length")
    `LRAST_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, do_step && (n_left == '0), !r_busy && r_out_valid && r_out_last, "last pixel did not end the line")
    `LRAST_ASSERT_NEXT(a_step_out, i_clk, i_rst_n, do_step, r_out_valid, "step word lost")

endmodule

/* rtl/core/line_rasterizer.sv */
// line rasterizer: walks an integer line one pixel per step word
// channels: i_cmd carries command words (opcode load or step with the two
// endpoints), o_pix carries pixel words (x, y, colour, last flag); both use
// valid/ready, a word moves when both are high. the colour register sits at
// apb address 0 and may be written only while no line is in flight.
// a load word sets up a new line and gives no pixel; each step word while a
// line is running gives one pixel, the final one flagged last; a step word
// with no line running is dropped.
// throughput: one command word per cycle while o_pix.ready is high; the error
// add, compare and coordinate update in the stepper are combinational.
// a step word accepted into the two-entry command queue is popped once it
// is at the head and the output register is free or being taken; the pop
// loads its pixel into the output register, where the sink can take it.
// when o_pix.ready is low the pixel is held, the stepper stops and the queue
// fills; i_cmd.ready drops once both queue entries are taken.
// reset clears the queue, the output register and the running line, and sets
// the colour to pure red; no clearing pass is needed.
module line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lrast_cmd_if.sink                           i_cmd,
    lrast_pix_if.source                         o_pix,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrast_pkg::PADDR_W-1:0]       paddr,
    input  logic [lrast_pkg::PDATA_W-1:0]       pwdata,
    output logic [lrast_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);
    import lrast_pkg::*;

    localparam int CW      = COORD_BITS;
    localparam int ENTRY_W = 1 + 4 * CW + DIRS_W;

    logic [COLOR_W-1:0] r_color;
    logic               reg_sel;

    logic               push, full, pop, empty;
    logic               f_is_load, b_is_load;
    logic [CW-1:0]      f_x, f_y, f_major, f_minor;
    logic [CW-1:0]      b_x, b_y, b_major, b_minor;
    t_dirs              f_dirs, b_dirs;
    logic [ENTRY_W-1:0] q_in, q_out;

    // register decode uses the word address
    assign reg_sel = (paddr[2] == REG_PIXEL_COLOR);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(PDATA_W-COLOR_W){1'b0}}, r_color} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_color <= pwdata[COLOR_W-1:0];
        end
    end

    lrast_front #(.CW(CW)) u_front (
        .i_cmd     (i_cmd),
        .i_full    (full),
        .o_push    (push),
        .o_is_load (f_is_load),
        .o_start_x (f_x),
        .o_start_y (f_y),
        .o_major   (f_major),
        .o_minor   (f_minor),
        .o_dirs    (f_dirs)
    );

    assign q_in = {f_is_load, f_x, f_y, f_major, f_minor, f_dirs};
    assign {b_is_load, b_x, b_y, b_major, b_minor, b_dirs} = q_out;

    lrast_fifo #(.WIDTH(ENTRY_W), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    lrast_back #(.CW(CW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .o_pop     (pop),
        .i_is_load (b_is_load),
        .i_start_x (b_x),
        .i_start_y (b_y),
        .i_major   (b_major),
        .i_minor   (b_minor),
        .i_dirs    (b_dirs),
        .i_color   (r_color),
        .o_pix     (o_pix)
    );

endmodule
